// File: hw/rtl/gtba_pkg.sv
// Shared types, constants and coefficient table functions for the tone bank.
`default_nettype none
package gtba_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int STATE_W     = 40;
    localparam int COEF_W      = 18;
    localparam int TONE_W      = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam int DEF_NUM_BINS          = 48;
    localparam int DEF_SAMPLE_RATE_HZ    = 44100;
    localparam int DEF_BASE_FREQ_MILLIHZ = 65406;
    localparam int DEF_STEPS_PER_OCTAVE  = 12;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef struct packed {
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
    } queue_entry_t;

    // Rounds v / 2^sh, halves away from zero.
    function automatic logic signed [63:0] round_shift64(input logic signed [63:0] v,
                                                         input int sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 1);
        if (v < 0) begin
            return (v + half - 64'sd1) >>> sh;
        end
        return (v + half) >>> sh;
    endfunction

    // r^n in Q30, truncated after each product; zero once it passes 2.0.
    function automatic logic [63:0] q30_pow(input logic [63:0] r, input int n);
        logic [63:0] acc;
        acc = Q30_ONE;
        for (int i = 0; i < n; i++) begin
            acc = (acc * r) >> 30;
            if (acc > 2 * Q30_ONE) begin
                return 64'd0;
            end
        end
        return acc;
    endfunction

    // Largest Q30 ratio whose steps-th power stays at or below 2.0.
    function automatic logic [63:0] ratio_search(input int steps);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] pw;
        lo = Q30_ONE;
        hi = 2 * Q30_ONE;
        while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 2;
            pw  = q30_pow(mid, steps);
            if (pw != 64'd0 && pw <= 2 * Q30_ONE) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    // cos of a phase given in Q32 turns, result in Q30.
    function automatic logic signed [63:0] cos_turns(input logic [31:0] u_in);
        logic [31:0]        u;
        logic               neg;
        logic [63:0]        theta;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        u   = u_in;
        neg = 1'b0;
        if (u > 32'h8000_0000) begin
            u = 32'd0 - u;
        end
        if (u > 32'h4000_0000) begin
            u   = 32'h8000_0000 - u;
            neg = 1'b1;
        end
        theta = ({32'd0, u} * PI_Q30) >> 31;
        th2   = (theta * theta) >> 30;
        term  = Q30_ONE;
        sum   = signed'(term);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return neg ? -sum : sum;
    endfunction

    // Q2.16 coefficient 2cos(w) for a bin at octave q and step m.
    function automatic logic signed [COEF_W-1:0] coef_calc(input logic [63:0] p0,
                                                          input logic [63:0] ratio,
                                                          input int q, input int m);
        logic [63:0]        ph;
        logic signed [63:0] c;
        ph = (p0 * q30_pow(ratio, m)) >> 30;
        if (q < 32) begin
            ph = (ph << q) & 64'hFFFF_FFFF;
        end else begin
            ph = 64'd0;
        end
        c = round_shift64(cos_turns(ph[31:0]), 13);
        if (c > 64'sd131071) begin
            c = 64'sd131071;
        end
        if (c < -64'sd131072) begin
            c = -64'sd131072;
        end
        return COEF_W'(c);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gtba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gtba_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 48
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/gtba_front.sv
// Input side: accepts sample items and holds them in a short queue.
`default_nettype none
module gtba_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    output logic                       q_valid,
    input  wire logic                  q_pop,
    output gtba_pkg::queue_entry_t     q_entry
);
    localparam int DEPTH = gtba_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    gtba_pkg::queue_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign s_axis_tready = (count_reg != (PTR_W+1)'(DEPTH));
    assign q_valid       = (count_reg != '0);
    assign q_entry       = entries_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_pop;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= '{last: s_axis_tlast, sample: s_axis_tdata};
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/gtba_back.sv
// Processing side: walks the bins per sample, scores power, picks the strongest.
`default_nettype none
module gtba_back #(
    parameter int NUM_BINS          = gtba_pkg::DEF_NUM_BINS,
    parameter int SAMPLE_RATE_HZ    = gtba_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int BASE_FREQ_MILLIHZ = gtba_pkg::DEF_BASE_FREQ_MILLIHZ,
    parameter int STEPS_PER_OCTAVE  = gtba_pkg::DEF_STEPS_PER_OCTAVE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  wire gtba_pkg::queue_entry_t         q_entry,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [gtba_pkg::TONE_W-1:0]         out_tone
);
    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int SW    = gtba_pkg::STATE_W;
    localparam int CW    = gtba_pkg::COEF_W;
    localparam int HALF  = SW / 2;
    localparam logic [63:0] P0 =
        ((64'(BASE_FREQ_MILLIHZ) << 32) + 64'(SAMPLE_RATE_HZ) * 64'd500)
        / (64'(SAMPLE_RATE_HZ) * 64'd1000);
    localparam logic [63:0] RATIO_Q30 = gtba_pkg::ratio_search(STEPS_PER_OCTAVE);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_PW1  = 3'd4;
    localparam logic [2:0] ST_PW2  = 3'd5;
    localparam logic [2:0] ST_PW3  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic signed [CW-1:0] coef_rom [NUM_BINS];
    for (genvar g = 0; g < NUM_BINS; g++) begin : g_rom
        localparam int Q = g / STEPS_PER_OCTAVE;
        localparam int M = g % STEPS_PER_OCTAVE;
        assign coef_rom[g] = gtba_pkg::coef_calc(P0, RATIO_Q30, Q, M);
    end

    logic [2:0]                state_reg, state_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic signed [15:0]        x_reg, x_next;
    logic                      last_reg, last_next;
    logic signed [CW-1:0]      coef_reg, coef_next;
    logic signed [SW-1:0]      s1_reg, s1_next, s2_reg, s2_next;
    logic signed [CW+HALF:0]   pp_lo_reg, pp_lo_next;
    logic signed [CW+HALF-1:0] pp_hi_reg, pp_hi_next;
    logic signed [31:0]        t1_reg, t1_next, t2_reg, t2_next;
    logic signed [63:0]        sq1_reg, sq1_next, sq2_reg, sq2_next;
    logic signed [CW+31:0]     ct_reg, ct_next;
    logic signed [63:0]        cross_reg, cross_next;
    logic [63:0]               best_power_reg, best_power_next;
    logic [IDX_W-1:0]          best_index_reg, best_index_next;
    logic [NUM_BINS-1:0]       valid_reg, valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [gtba_pkg::TONE_W-1:0] out_tone_reg, out_tone_next;

    logic                      ram_we;
    logic [2*SW-1:0]           ram_wdata, ram_rdata;
    logic signed [SW-1:0]      rd_s1, rd_s2;
    logic signed [CW+SW-1:0]   prod;
    logic signed [CW+SW-17:0]  prod_rnd;
    logic signed [CW+SW-16:0]  v_wide;
    logic signed [SW-1:0]      v_sat;
    logic signed [SW:0]        s1_ext, v_ext;
    logic signed [CW+15:0]     ct_rnd;
    logic signed [63:0]        pw;
    logic [63:0]               upw;

    gtba_ram #(.WIDTH(2 * SW), .DEPTH(NUM_BINS)) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (k_reg),
        .wdata (ram_wdata),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign rd_s1 = valid_reg[k_reg] ? ram_rdata[2*SW-1:SW] : '0;
    assign rd_s2 = valid_reg[k_reg] ? ram_rdata[SW-1:0] : '0;

    always_comb begin
        prod     = ((CW+SW)'(pp_hi_reg) <<< HALF) + (CW+SW)'(pp_lo_reg);
        prod_rnd = (CW+SW-16)'((prod + (prod < 0 ? (CW+SW)'(32767)
                                                 : (CW+SW)'(32768))) >>> 16);
        v_wide   = (CW+SW-15)'(prod_rnd) - (CW+SW-15)'(s2_reg) + (CW+SW-15)'(x_reg);
        if (v_wide > (CW+SW-15)'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
            v_sat = {1'b0, {(SW-1){1'b1}}};
        end else if (v_wide < (CW+SW-15)'(signed'({1'b1, {(SW-1){1'b0}}}))) begin
            v_sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            v_sat = SW'(v_wide);
        end
        s1_ext   = (SW+1)'(s1_reg);
        v_ext    = (SW+1)'(v_sat);
        ct_rnd   = (CW+16)'((ct_reg + (ct_reg < 0 ? (CW+32)'(32767)
                                                  : (CW+32)'(32768))) >>> 16);
        pw       = sq1_reg + sq2_reg - cross_reg;
        upw      = (pw > 0) ? pw : 64'd0;
        ram_wdata = {v_sat, s1_reg};
    end

    always_comb begin
        state_next      = state_reg;
        k_next          = k_reg;
        x_next          = x_reg;
        last_next       = last_reg;
        coef_next       = coef_reg;
        s1_next         = s1_reg;
        s2_next         = s2_reg;
        pp_lo_next      = pp_lo_reg;
        pp_hi_next      = pp_hi_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        sq1_next        = sq1_reg;
        sq2_next        = sq2_reg;
        ct_next         = ct_reg;
        cross_next      = cross_reg;
        best_power_next = best_power_reg;
        best_index_next = best_index_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_tone_next   = out_tone_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                q_pop = 1'b1;
                if (q_valid) begin
                    x_next     = q_entry.sample;
                    last_next  = q_entry.last;
                    k_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                coef_next  = coef_rom[k_reg];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                s1_next    = rd_s1;
                s2_next    = rd_s2;
                pp_lo_next = coef_reg * signed'({1'b0, rd_s1[HALF-1:0]});
                pp_hi_next = coef_reg * signed'(rd_s1[SW-1:HALF]);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                ram_we            = 1'b1;
                valid_next[k_reg] = 1'b1;
                t1_next = 32'((v_ext + (v_ext < 0 ? (SW+1)'(255) : (SW+1)'(256))) >>> 9);
                t2_next = 32'((s1_ext + (s1_ext < 0 ? (SW+1)'(255) : (SW+1)'(256))) >>> 9);
                if (last_reg) begin
                    state_next = ST_PW1;
                end else if (k_reg == IDX_W'(NUM_BINS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_PW1: begin
                sq1_next   = 64'(t1_reg * t1_reg);
                sq2_next   = 64'(t2_reg * t2_reg);
                ct_next    = coef_reg * t1_reg;
                state_next = ST_PW2;
            end
            ST_PW2: begin
                cross_next = 64'(ct_rnd * t2_reg);
                state_next = ST_PW3;
            end
            ST_PW3: begin
                if (k_reg == '0 || upw >= best_power_reg) begin
                    best_power_next = upw;
                    best_index_next = k_reg;
                end
                if (k_reg == IDX_W'(NUM_BINS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_OUT: begin
                // Hand the decision to the output register, then start a fresh block.
                if (!out_valid_reg) begin
                    out_valid_next  = 1'b1;
                    out_tone_next   = gtba_pkg::TONE_W'(best_index_reg);
                    valid_next      = '0;
                    best_power_next = '0;
                    best_index_next = '0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            valid_reg      <= '0;
            best_power_reg <= '0;
            best_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            valid_reg      <= valid_next;
            best_power_reg <= best_power_next;
            best_index_reg <= best_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        last_reg     <= last_next;
        coef_reg     <= coef_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        pp_lo_reg    <= pp_lo_next;
        pp_hi_reg    <= pp_hi_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        sq1_reg      <= sq1_next;
        sq2_reg      <= sq2_next;
        ct_reg       <= ct_next;
        cross_reg    <= cross_next;
        out_tone_reg <= out_tone_next;
    end

    assign out_valid = out_valid_reg;
    assign out_tone  = out_tone_reg;
endmodule
`default_nettype wire

// File: hw/rtl/goertzel_tone_bank_argmax.sv
// Top level of the Goertzel semitone filter bank with strongest-bin output.
//
// The slave channel takes one signed 16-bit audio sample per item, with
// tlast set on the final sample of a block. Each sample runs through the
// Goertzel recurrence of every bin, one bin at a time on a shared multiply
// path over the bin state RAM. Each bin of a plain sample takes a read,
// a multiply and an accumulate step. Each bin of the final sample of a
// block also has its power scored right after its update, in three more
// stages that form the products and compare against the best bin so far.
// After the last sample the master channel carries one item, the index of
// the strongest bin, ties going to the higher index; all bin state is then
// cleared at once through per-bin valid flags.
// A four-item queue sits in front of the processing side, so samples keep
// being accepted while a bin pass runs. A result waits in an output register
// while the receiver stalls; the next block's samples are still processed,
// and only the next decision waits for that register to empty.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result and marks every bin state as zero.
`default_nettype none
module goertzel_tone_bank_argmax #(
    parameter int NUM_BINS          = gtba_pkg::DEF_NUM_BINS,
    parameter int SAMPLE_RATE_HZ    = gtba_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int BASE_FREQ_MILLIHZ = gtba_pkg::DEF_BASE_FREQ_MILLIHZ,
    parameter int STEPS_PER_OCTAVE  = gtba_pkg::DEF_STEPS_PER_OCTAVE
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [5:0] best_tone, [7:6] zero
);
    logic                          q_valid;
    logic                          q_pop;
    gtba_pkg::queue_entry_t        q_entry;
    logic [gtba_pkg::TONE_W-1:0]   best_tone;

    gtba_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_entry       (q_entry)
    );

    gtba_back #(
        .NUM_BINS          (NUM_BINS),
        .SAMPLE_RATE_HZ    (SAMPLE_RATE_HZ),
        .BASE_FREQ_MILLIHZ (BASE_FREQ_MILLIHZ),
        .STEPS_PER_OCTAVE  (STEPS_PER_OCTAVE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tone  (best_tone)
    );

    assign m_axis_tdata = {2'b00, best_tone};
endmodule
`default_nettype wire
